// File: sv/usd_pkg.sv
// Shared types and constants for the byte-serial UTF-8 stream decoder.
// Used by the front, queue, back and top level. No dependencies.
package usd_pkg;

  localparam int unsigned CpW    = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CntW   = 3;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [CpW-1:0] ReplResetVal = 32'h0000_001A;

  // One queue entry: an optional leading replacement word, then the main word.
  typedef struct packed {
    logic           pre_rep;
    logic           main_rep;
    logic [CpW-1:0] main_cp;
  } usd_entry_t;

endpackage

// File: sv/usd_front.sv
// Front end: accepts stream bytes, tracks the multi-byte sequence state and
// builds queue entries. Depends on usd_pkg.
module usd_front import usd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] data_byte_i,
  output logic             push_o,
  output usd_entry_t       entry_o
);

  logic [CpW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  len_q, len_d;
  logic [ByteW-1:0] lead_q, lead_d;

  logic [CntW-1:0]  lead_n;
  logic [CpW-1:0]   acc_cat;
  logic [CpW-1:0]   lead_bits;
  logic [CpW-1:0]   value;
  logic             is_cont;
  logic             brk;
  logic             idle_has;
  logic             idle_rep;
  logic [CpW-1:0]   idle_cp;

  always_comb begin
    unique casez (data_byte_i)
      8'b110?????: lead_n = 3'd1;
      8'b1110????: lead_n = 3'd2;
      8'b11110???: lead_n = 3'd3;
      8'b111110??: lead_n = 3'd4;
      8'b1111110?: lead_n = 3'd5;
      8'b1111111?: lead_n = 3'd6;
      default:     lead_n = 3'd0;
    endcase
  end

  // lead payload: low 6-n bits placed at bit 6n
  always_comb begin
    unique case (len_q)
      3'd1:    lead_bits = {21'b0, lead_q[4:0], 6'b0};
      3'd2:    lead_bits = {16'b0, lead_q[3:0], 12'b0};
      3'd3:    lead_bits = {11'b0, lead_q[2:0], 18'b0};
      3'd4:    lead_bits = {6'b0, lead_q[1:0], 24'b0};
      3'd5:    lead_bits = {1'b0, lead_q[0], 30'b0};
      default: lead_bits = '0;
    endcase
  end

  assign acc_cat = {acc_q[CpW-7:0], data_byte_i[5:0]};
  assign value   = acc_cat | lead_bits;
  assign is_cont = (data_byte_i[7:6] == 2'b10);

  always_comb begin
    acc_d    = acc_q;
    rem_d    = rem_q;
    len_d    = len_q;
    lead_d   = lead_q;
    push_o   = 1'b0;
    entry_o  = '0;
    brk      = 1'b0;
    idle_has = 1'b0;
    idle_rep = 1'b0;
    idle_cp  = '0;
    if (rem_q != '0 && is_cont) begin
      acc_d = acc_cat;
      rem_d = rem_q - 3'd1;
      if (rem_q == 3'd1) begin
        push_o           = 1'b1;
        entry_o.main_rep = (value == '0);
        entry_o.main_cp  = value;
      end
    end else begin
      brk = (rem_q != '0);
      if (brk) begin
        rem_d = '0;
      end
      if (data_byte_i == '0) begin
        rem_d = '0;
        len_d = '0;
        acc_d = '0;
      end else if (!data_byte_i[7]) begin
        idle_has = 1'b1;
        idle_cp  = {{(CpW-ByteW){1'b0}}, data_byte_i};
      end else if (!data_byte_i[6]) begin
        idle_has = 1'b1;
        idle_rep = 1'b1;
      end else begin
        lead_d = data_byte_i;
        len_d  = lead_n;
        rem_d  = lead_n;
        acc_d  = '0;
      end
      push_o           = brk | idle_has;
      entry_o.pre_rep  = brk & idle_has;
      entry_o.main_rep = idle_has ? idle_rep : 1'b1;
      entry_o.main_cp  = idle_cp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      len_q  <= '0;
      lead_q <= '0;
    end else if (accept_i) begin
      acc_q  <= acc_d;
      rem_q  <= rem_d;
      len_q  <= len_d;
      lead_q <= lead_d;
    end
  end

endmodule

// File: sv/usd_queue.sv
// Small FIFO of decoded entries between the front and back ends.
// Depends on usd_pkg.
module usd_queue import usd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  usd_entry_t entry_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       head_valid_o,
  output usd_entry_t head_o
);

  usd_entry_t       mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o       = (cnt_q == QCntW'(QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: sv/usd_back.sv
// Back end: expands queue entries into one or two output words and holds
// them in the output register. Depends on usd_pkg.
module usd_back import usd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  usd_entry_t     head_i,
  input  logic [CpW-1:0] repl_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [CpW-1:0] code_point_o,
  output logic           is_replacement_o,
  output logic           last_of_run_o
);

  logic           phase_q;
  logic           out_valid_q;
  logic [CpW-1:0] cp_q;
  logic           rep_q;
  logic           last_q;
  logic           emit_pre;
  logic           use_rep;
  logic           load;

  assign emit_pre = head_i.pre_rep && !phase_q;
  assign use_rep  = emit_pre || head_i.main_rep;
  assign load     = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o    = load && !emit_pre;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        phase_q     <= emit_pre;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= use_rep ? repl_i : head_i.main_cp;
      rep_q  <= use_rep;
      last_q <= !emit_pre;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign code_point_o     = cp_q;
  assign is_replacement_o = rep_q;
  assign last_of_run_o    = last_q;

endmodule

// File: sv/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: config register, front end, entry queue, back end.
// The first word of a byte goes through the entry queue, then the output register.
// Throughput: one byte per cycle while the queue has room; a byte may yield two words.
// Input stall comes from the 4-entry queue filling up, never from output stall directly.
// Reset (async, active low): sequence state idle, queue empty, replacement value 0x1A.
// Depends on usd_pkg, usd_front, usd_queue, usd_back.
module utf8_stream_decoder import usd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CpW-1:0]   cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] data_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CpW-1:0]   code_point_o,
  output logic             is_replacement_o,
  output logic             last_of_run_o
);

  logic [CpW-1:0] repl_q;
  logic           accept;
  logic           push;
  usd_entry_t     entry;
  logic           q_full;
  logic           head_valid;
  usd_entry_t     head;
  logic           pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= ReplResetVal;
    end else if (cfg_we_i) begin
      repl_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  usd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .entry_o     (entry)
  );

  usd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push && accept),
    .entry_i      (entry),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  usd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .repl_i           (repl_q),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .code_point_o     (code_point_o),
    .is_replacement_o (is_replacement_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

// File: sv/usd_checker.sv
// Port-level checker for utf8_stream_decoder, attached by bind.
// Depends on usd_pkg.
module usd_checker import usd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [CpW-1:0]   code_point_o,
  input logic             is_replacement_o,
  input logic             last_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_point_o)
      && $stable(is_replacement_o) && $stable(last_of_run_o))
    else $error("stalled output word changed");

  a_first_is_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> is_replacement_o)
    else $error("non-final word is not a replacement");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o && !out_stall_i |=> out_valid_o && last_of_run_o)
    else $error("second word of a byte did not follow");

  a_no_zero_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_replacement_o |-> code_point_o != '0)
    else $error("zero code point emitted without replacement flag");

endmodule

bind utf8_stream_decoder usd_checker u_usd_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for utf8_stream_decoder: directed byte table, then random
// UTF-8 style streams under random stalls, checked word by word against a predictor.
// Depends on usd_pkg and the utf8_stream_decoder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import usd_pkg::*;

  localparam int unsigned NDir = 25;
  localparam int unsigned PhaseBytes = 225;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned LongHold = 300;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           rep;
    logic           last;
  } cp_word_t;

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             typed;
    logic [1:0]       n;
    logic [CpW-1:0]   cp0;
    logic             rep0;
    logic [CpW-1:0]   cp1;
    logic             rep1;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CpW-1:0]   cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] data_byte = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CpW-1:0]   code_point;
  logic             is_repl;
  logic             last_of_run;

  // decoder state mirror
  logic [CpW-1:0]   repl = ReplResetVal;
  logic [CpW-1:0]   acc = '0;
  logic [CntW-1:0]  rem = '0;
  logic [CntW-1:0]  seq_len = '0;
  logic [ByteW-1:0] lead = '0;
  cp_word_t         pred_w [2];
  int unsigned      pred_n;

  cp_word_t    pending_cp_q [$];
  int unsigned err_cnt = 0;
  int unsigned idle_cnt = 0;
  int unsigned phase_bytes;
  bit          no_gaps = 1'b0;
  bit          rx_steady = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned rx_left = 0;

  dir_row_t dir_tab [NDir] = '{
    '{8'h00, 1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'h41, 1'b1, 2'd1, 32'h41, 1'b0, 32'h0, 1'b0},
    '{8'h80, 1'b1, 2'd1, ReplResetVal, 1'b1, 32'h0, 1'b0},
    '{8'hC3, 1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'hA9, 1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'hC0, 1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'h80, 1'b1, 2'd1, ReplResetVal, 1'b1, 32'h0, 1'b0},
    '{8'hE2, 1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'h82, 1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'hAC, 1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'hF0, 1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'h41, 1'b1, 2'd2, ReplResetVal, 1'b1, 32'h41, 1'b0},
    '{8'hE0, 1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'hC2, 1'b1, 2'd1, ReplResetVal, 1'b1, 32'h0, 1'b0},
    '{8'h80, 1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'hFF, 1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'hBF, 1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'hBF, 1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'hBF, 1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'hBF, 1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'hBF, 1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'hBF, 1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'hF8, 1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'h81, 1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{8'h00, 1'b1, 2'd1, ReplResetVal, 1'b1, 32'h0, 1'b0}
  };

  utf8_stream_decoder i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .code_point_o     (code_point),
    .is_replacement_o (is_repl),
    .last_of_run_o    (last_of_run)
  );

  always #6 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(10, 40);
  endfunction

  function automatic void emit(input logic [CpW-1:0] cp, input logic rep);
    pred_w[pred_n] = '{cp: cp, rep: rep, last: 1'b0};
    pred_n++;
  endfunction

  function automatic void idle_byte(input logic [ByteW-1:0] b);
    int ones;
    ones = 0;
    if (b == 8'h00) begin
      rem = '0;
      seq_len = '0;
      acc = '0;
    end else if (b < 8'h80) begin
      emit({24'h0, b}, 1'b0);
    end else if (b < 8'hC0) begin
      emit(repl, 1'b1);
    end else begin
      while (ones < 8 && b[7-ones]) ones++;
      if (ones > 7) ones = 7;
      lead = b;
      seq_len = CntW'(ones - 1);
      rem = CntW'(ones - 1);
      acc = '0;
    end
  endfunction

  function automatic void decode_byte(input logic [ByteW-1:0] b);
    logic [CpW-1:0] value;
    logic [CpW-1:0] mask;
    pred_n = 0;
    if (rem != 0) begin
      if (b[7:6] == 2'b10) begin
        acc = {acc[CpW-7:0], b[5:0]};
        rem--;
        if (rem == 0) begin
          value = acc;
          if (seq_len < 6) begin
            mask = (32'd1 << (6 - seq_len)) - 32'd1;
            value |= ({24'h0, lead} & mask) << (6 * seq_len);
          end
          if (value == 0) emit(repl, 1'b1);
          else emit(value, 1'b0);
        end
      end else begin
        emit(repl, 1'b1);
        rem = '0;
        idle_byte(b);
      end
    end else begin
      idle_byte(b);
    end
    if (pred_n > 0) pred_w[pred_n-1].last = 1'b1;
  endfunction

  task automatic push_byte(input logic [ByteW-1:0] b, input bit use_row, input dir_row_t row);
    int unsigned g;
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    phase_bytes++;
    decode_byte(b);
    if (use_row) begin
      if (row.n >= 1) pending_cp_q.push_back('{cp: row.cp0, rep: row.rep0, last: row.n == 1});
      if (row.n == 2) pending_cp_q.push_back('{cp: row.cp1, rep: row.rep1, last: 1'b1});
    end else begin
      for (int i = 0; i < pred_n; i++) pending_cp_q.push_back(pred_w[i]);
    end
    g = no_gaps ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [ByteW-1:0] lead_for(input int n);
    if (n == 6) return 8'hFE | ByteW'($urandom_range(0, 1));
    return ((8'hFF << (7 - n)) & 8'hFF) | (ByteW'($urandom) & ((8'd1 << (6 - n)) - 8'd1));
  endfunction

  task automatic send_group();
    int unsigned r;
    int n;
    int k;
    logic [ByteW-1:0] b;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      push_byte(ByteW'($urandom_range(1, 127)), 1'b0, '0);
    end else if (r < 82) begin
      n = (r < 70) ? $urandom_range(1, 6) : $urandom_range(2, 6);
      k = (r < 70) ? n : $urandom_range(0, n - 1);
      push_byte(lead_for(n), 1'b0, '0);
      for (int i = 0; i < k; i++) push_byte({2'b10, 6'($urandom)}, 1'b0, '0);
      if (r >= 70) begin
        do b = ByteW'($urandom); while (b[7:6] == 2'b10);
        push_byte(b, 1'b0, '0);
      end
    end else if (r < 88) begin
      push_byte({2'b10, 6'($urandom)}, 1'b0, '0);
    end else if (r < 93) begin
      push_byte(8'h00, 1'b0, '0);
    end else begin
      push_byte(ByteW'($urandom), 1'b0, '0);
    end
  endtask

  task automatic drain();
    while (pending_cp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_repl(input logic [CpW-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    repl = v;
  endtask

  task automatic report_err(input string what, input logic [CpW-1:0] got,
                            input logic [CpW-1:0] want);
    $display("%0t ERROR %s: got %h want %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      rx_left <= LongHold;
      out_stall <= 1'b1;
    end else if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if (rx_steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30);
      rx_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cp_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cp_q.size() == 0) begin
        report_err("word with none pending", code_point, '0);
      end else begin
        w = pending_cp_q.pop_front();
        if (code_point !== w.cp) report_err("code_point", code_point, w.cp);
        if (is_repl !== w.rep) report_err("is_replacement", 32'(is_repl), 32'(w.rep));
        if (last_of_run !== w.last) report_err("last_of_run", 32'(last_of_run), 32'(w.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    logic [CpW-1:0] cfg_vals [5];
    cfg_vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'($urandom), 32'h0000_FFFD, ReplResetVal};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NDir; i++) push_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i]);
    in_valid <= 1'b0;
    drain();

    for (int p = 0; p < 5; p++) begin
      set_repl(cfg_vals[p]);
      if (p == 1) begin
        hold_reqs++;
        no_gaps = 1'b1;
      end
      if (p == 2) begin
        no_gaps = 1'b1;
        rx_steady = 1'b1;
      end
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) begin
        send_group();
        if (phase_bytes >= 60) begin
          no_gaps = 1'b0;
          rx_steady = 1'b0;
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
